// ----- rtl/a2b_pkg.sv -----
// Shared types and constants for the AVCC to Annex B converter.
package a2b_pkg;

    localparam int PREFIX_BYTES    = 4;
    localparam int PREFIX_CNT_W    = $clog2(PREFIX_BYTES);
    localparam int LEN_W           = 8 * PREFIX_BYTES;
    localparam int LEN_HOLD_W      = 8 * (PREFIX_BYTES - 1);
    localparam int START_CODE_LEN  = 4;
    localparam int MIN_PACKET      = 5;
    localparam int SEEN_W          = 3;
    localparam int MAX_RESULTS     = 5;
    localparam int RES_CNT_W       = 3;

    localparam logic [7:0] SC_LAST_BYTE = 8'h01;
    localparam logic [7:0] TYPE_MASK    = 8'h1F;

    localparam logic [4:0] NAL_IDR = 5'd5;
    localparam logic [4:0] NAL_SPS = 5'd7;
    localparam logic [4:0] NAL_PPS = 5'd8;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_OVERRUN  = 2'd2,
        ST_NO_NAL   = 2'd3
    } t_status;

    typedef enum logic {
        KIND_STREAM = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        logic                 sc;
        logic                 pay;
        logic                 stat;
        logic [7:0]           pay_byte;
        logic [4:0]           nal_type;
        t_status              status;
        logic                 has_sps;
        logic                 has_pps;
        logic                 is_key;
        logic [RES_CNT_W-1:0] cnt;
    } t_bundle;

endpackage

// ----- rtl/a2b_if.sv -----
// Channel interfaces for the AVCC input bytes and the Annex B result words.
interface a2b_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       packet_end;

    modport source (output valid, output in_byte, output packet_end, input ready);
    modport sink   (input valid, input in_byte, input packet_end, output ready);
endinterface

interface a2b_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic       is_start_code;
    logic [4:0] nal_type;
    logic [1:0] status;
    logic       has_sps;
    logic       has_pps;
    logic       is_key;
    logic       run_end;

    modport source (output valid, output kind, output out_byte, output is_start_code,
                    output nal_type, output status, output has_sps, output has_pps,
                    output is_key, output run_end, input ready);
    modport sink   (input valid, input kind, input out_byte, input is_start_code,
                    input nal_type, input status, input has_sps, input has_pps,
                    input is_key, input run_end, output ready);
endinterface

// ----- rtl/avcc_to_annexb_converter.sv -----
// Top level: AVCC length-prefixed H.264 packet to Annex B byte stream converter.
//
// i_in carries one packet byte per word, packet_end set on the final byte.
// o_out carries result words: stream bytes (kind 0) and one status word per
// packet (kind 1); run_end marks the last word caused by one input byte.
// A byte is parsed in the cycle it is accepted and its results (up to five:
// four start-code bytes and a status word) are held in a result register and
// shown from the next cycle on, one word per cycle while o_out.ready is high.
// A payload byte gives one word (two with packet_end), so the block takes one
// byte per cycle while o_out.ready is high; a byte that completes a nonzero
// length prefix gives four or five words on the single result port. The next
// byte is accepted in the cycle the last word of the previous byte is taken.
// Reset clears the parser and drops any held results. When the receiver
// stalls, the held word stays on o_out and i_in.ready stays low until the
// last word of the held group is taken.
module avcc_to_annexb_converter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    a2b_in_if.sink    i_in,
    a2b_out_if.source o_out
);

    logic                                   r_in_payload, n_in_payload;
    logic [a2b_pkg::PREFIX_CNT_W-1:0]       r_prefix_count, n_prefix_count;
    logic [a2b_pkg::LEN_HOLD_W-1:0]         r_length_shift, n_length_shift;
    logic [a2b_pkg::LEN_W-1:0]              r_bytes_left, n_bytes_left;
    logic [4:0]                             r_current_type, n_current_type;
    logic                                   r_first_pending, n_first_pending;
    logic [a2b_pkg::SEEN_W-1:0]             r_bytes_seen, n_bytes_seen;
    logic                                   r_any_nal, n_any_nal;
    logic [2:0]                             r_seen_flags, n_seen_flags;

    logic                                   r_busy;
    logic [a2b_pkg::RES_CNT_W-1:0]          r_pos;
    a2b_pkg::t_bundle                       r_bundle, n_bundle;

    logic                                   accept;
    logic                                   out_take;
    logic                                   at_last;
    logic [a2b_pkg::LEN_W-1:0]              full_len;
    logic [a2b_pkg::LEN_W-1:0]              left_dec;
    a2b_pkg::t_status                       st;

    assign at_last  = (r_pos == r_bundle.cnt - a2b_pkg::RES_CNT_W'(1));
    assign out_take = o_out.valid && o_out.ready;
    assign i_in.ready = !r_busy || (o_out.ready && at_last);
    assign accept   = i_in.valid && i_in.ready;
    assign full_len = {r_length_shift, i_in.in_byte};
    assign left_dec = r_bytes_left - a2b_pkg::LEN_W'(1);

    always_comb begin
        n_in_payload    = r_in_payload;
        n_prefix_count  = r_prefix_count;
        n_length_shift  = r_length_shift;
        n_bytes_left    = r_bytes_left;
        n_current_type  = r_current_type;
        n_first_pending = r_first_pending;
        n_any_nal       = r_any_nal;
        n_seen_flags    = r_seen_flags;
        n_bytes_seen    = r_bytes_seen;
        n_bundle        = '0;
        st              = a2b_pkg::ST_OK;

        if (r_bytes_seen < a2b_pkg::SEEN_W'(a2b_pkg::MIN_PACKET)) begin
            n_bytes_seen = r_bytes_seen + a2b_pkg::SEEN_W'(1);
        end

        if (!r_in_payload) begin
            n_length_shift = full_len[a2b_pkg::LEN_HOLD_W-1:0];
            if (r_prefix_count == a2b_pkg::PREFIX_CNT_W'(a2b_pkg::PREFIX_BYTES - 1)) begin
                n_prefix_count = '0;
                n_length_shift = '0;
                if (full_len != '0) begin
                    n_bundle.sc     = 1'b1;
                    n_any_nal       = 1'b1;
                    n_in_payload    = 1'b1;
                    n_bytes_left    = full_len;
                    n_first_pending = 1'b1;
                end
            end else begin
                n_prefix_count = r_prefix_count + a2b_pkg::PREFIX_CNT_W'(1);
            end
        end else begin
            if (r_first_pending) begin
                n_current_type  = 5'(i_in.in_byte & a2b_pkg::TYPE_MASK);
                n_first_pending = 1'b0;
                if (n_current_type == a2b_pkg::NAL_SPS) begin
                    n_seen_flags[0] = 1'b1;
                end else if (n_current_type == a2b_pkg::NAL_PPS) begin
                    n_seen_flags[1] = 1'b1;
                end else if (n_current_type == a2b_pkg::NAL_IDR) begin
                    n_seen_flags[2] = 1'b1;
                end
            end
            n_bundle.pay      = 1'b1;
            n_bundle.pay_byte = i_in.in_byte;
            n_bundle.nal_type = n_current_type;
            n_bytes_left      = left_dec;
            if (left_dec == '0) begin
                n_in_payload   = 1'b0;
                n_prefix_count = '0;
                n_length_shift = '0;
            end
        end

        if (i_in.packet_end) begin
            priority if (n_bytes_seen < a2b_pkg::SEEN_W'(a2b_pkg::MIN_PACKET)) begin
                st = a2b_pkg::ST_SHORT;
            end else if (n_in_payload) begin
                st = a2b_pkg::ST_OVERRUN;
            end else if (!n_any_nal) begin
                st = a2b_pkg::ST_NO_NAL;
            end else begin
                st = a2b_pkg::ST_OK;
            end
            n_bundle.stat    = 1'b1;
            n_bundle.status  = st;
            n_bundle.has_sps = n_seen_flags[0];
            n_bundle.has_pps = n_seen_flags[1];
            n_bundle.is_key  = n_seen_flags[2];
            n_in_payload    = 1'b0;
            n_prefix_count  = '0;
            n_length_shift  = '0;
            n_bytes_left    = '0;
            n_current_type  = '0;
            n_first_pending = 1'b0;
            n_bytes_seen    = '0;
            n_any_nal       = 1'b0;
            n_seen_flags    = '0;
        end

        n_bundle.cnt = (n_bundle.sc ? a2b_pkg::RES_CNT_W'(a2b_pkg::START_CODE_LEN) : '0)
                     + a2b_pkg::RES_CNT_W'(n_bundle.pay)
                     + a2b_pkg::RES_CNT_W'(n_bundle.stat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload    <= 1'b0;
            r_prefix_count  <= '0;
            r_length_shift  <= '0;
            r_bytes_left    <= '0;
            r_current_type  <= '0;
            r_first_pending <= 1'b0;
            r_bytes_seen    <= '0;
            r_any_nal       <= 1'b0;
            r_seen_flags    <= '0;
            r_busy          <= 1'b0;
            r_pos           <= '0;
        end else begin
            if (accept) begin
                r_in_payload    <= n_in_payload;
                r_prefix_count  <= n_prefix_count;
                r_length_shift  <= n_length_shift;
                r_bytes_left    <= n_bytes_left;
                r_current_type  <= n_current_type;
                r_first_pending <= n_first_pending;
                r_bytes_seen    <= n_bytes_seen;
                r_any_nal       <= n_any_nal;
                r_seen_flags    <= n_seen_flags;
            end
            if (accept) begin
                r_busy <= (n_bundle.cnt != '0);
                r_pos  <= '0;
            end else if (out_take) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                    r_pos  <= '0;
                end else begin
                    r_pos <= r_pos + a2b_pkg::RES_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bundle <= n_bundle;
        end
    end

    always_comb begin
        o_out.valid         = r_busy;
        o_out.kind          = a2b_pkg::KIND_STREAM;
        o_out.out_byte      = '0;
        o_out.is_start_code = 1'b0;
        o_out.nal_type      = '0;
        o_out.status        = a2b_pkg::ST_OK;
        o_out.has_sps       = 1'b0;
        o_out.has_pps       = 1'b0;
        o_out.is_key        = 1'b0;
        o_out.run_end       = at_last;
        priority if (r_bundle.sc
                     && r_pos < a2b_pkg::RES_CNT_W'(a2b_pkg::START_CODE_LEN)) begin
            o_out.is_start_code = 1'b1;
            if (r_pos == a2b_pkg::RES_CNT_W'(a2b_pkg::START_CODE_LEN - 1)) begin
                o_out.out_byte = a2b_pkg::SC_LAST_BYTE;
            end
        end else if (r_bundle.pay && r_pos == '0) begin
            o_out.out_byte = r_bundle.pay_byte;
            o_out.nal_type = r_bundle.nal_type;
        end else begin
            o_out.kind    = a2b_pkg::KIND_STATUS;
            o_out.status  = r_bundle.status;
            o_out.has_sps = r_bundle.has_sps;
            o_out.has_pps = r_bundle.has_pps;
            o_out.is_key  = r_bundle.is_key;
        end
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos < r_bundle.cnt
                    && r_bundle.cnt <= a2b_pkg::RES_CNT_W'(a2b_pkg::MAX_RESULTS)))
        else $error("result position outside held group");

    a_accept_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (!r_busy || (out_take && o_out.run_end)))
        else $error("byte accepted while results still held");

    a_sc_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_start_code && o_out.run_end) |->
        (o_out.out_byte == a2b_pkg::SC_LAST_BYTE && r_bundle.stat == 1'b0))
        else $error("start code group ended early");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == a2b_pkg::KIND_STATUS) |-> o_out.run_end)
        else $error("status word not last in group");

endmodule
